@@ src/multi_level_lru_directory_top_macros.svh @@
// assertion macros for the multi-level lru directory
// uses clk and rst_n of the module that includes it
`ifndef MULTI_LEVEL_LRU_DIRECTORY_TOP_MACROS_SVH
`define MULTI_LEVEL_LRU_DIRECTORY_TOP_MACROS_SVH

// property checked every clock outside reset
`define MLLD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a consequence on the next clock
`define MLLD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ src/mlld_pkg.sv @@
// shared constants and types of the multi-level lru directory
// no dependencies
package mlld_pkg;

    localparam int MAX_LEVELS    = 8;
    localparam int MAX_PER_LEVEL = 64;

    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SLOT_W    = (MAX_PER_LEVEL > 1) ? $clog2(MAX_PER_LEVEL) : 1;
    localparam int NLV_W     = $clog2(MAX_LEVELS + 1);
    localparam int FILL_W    = $clog2(MAX_PER_LEVEL + 1);
    localparam int ADDR_W    = LVL_W + SLOT_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    localparam int TAG_W      = 32;
    localparam int ACT_W      = 2;
    localparam int HIT_LVL_W  = 3;
    localparam int CFG_LVL_W  = 4;
    localparam int CFG_CAP_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PROMOTE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd2;
    // unused code, behaves as a lookup
    localparam logic [ACT_W-1:0] ACT_SPARE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TAG_W-1:0]  wdata;
    } ram_req_t;

    typedef struct packed {
        logic                 hit;
        logic [HIT_LVL_W-1:0] level;
    } result_t;

endpackage

@@ src/mlld_tag_ram.sv @@
// tag memory: one write port, one read port with registered data
// depends on mlld_pkg
module mlld_tag_ram (
    input  logic                          clk,
    input  mlld_pkg::ram_req_t            req,
    output logic [mlld_pkg::TAG_W-1:0]    rdata
);
    import mlld_pkg::*;

    logic [TAG_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ src/mlld_ctrl.sv @@
// request sequencer: search, unlink, level cascade and insert over the tag memory
// depends on mlld_pkg and the assertion macro header
`include "multi_level_lru_directory_top_macros.svh"

module mlld_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mlld_pkg::ACT_W-1:0]         action,
    input  logic [mlld_pkg::TAG_W-1:0]         block,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlld_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mlld_pkg::ram_req_t                 ram_req,
    input  logic [mlld_pkg::TAG_W-1:0]         ram_rdata,
    output logic                               res_valid,
    input  logic                               res_ready,
    output mlld_pkg::result_t                  res
);
    import mlld_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_RD   = 10'b0000000010,
        ST_CMP  = 10'b0000000100,
        ST_RES  = 10'b0000001000,
        ST_SHR  = 10'b0000010000,
        ST_SHW  = 10'b0000100000,
        ST_POP  = 10'b0001000000,
        ST_CHK  = 10'b0010000000,
        ST_MVW  = 10'b0100000000,
        ST_INS  = 10'b1000000000
    } state_t;

    state_t             state_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [TAG_W-1:0]   blk_reg;
    logic [NLV_W-1:0]   lv_reg;
    logic [FILL_W-1:0]  pos_reg;
    logic               hit_reg;
    logic [LVL_W-1:0]   j_reg;
    logic [FILL_W-1:0]  fill_reg [MAX_LEVELS];
    logic [SLOT_W-1:0]  head_reg [MAX_LEVELS];
    logic [CFG_LVL_W-1:0] levels_cfg_reg;
    logic [CFG_CAP_W-1:0] cap_cfg_reg;

    logic [NLV_W-1:0]   nl_eff;
    logic [FILL_W-1:0]  cap_eff;
    logic [LVL_W-1:0]   sel;
    logic [FILL_W-1:0]  fill_sel;
    logic [SLOT_W-1:0]  head_sel;
    logic [SLOT_W-1:0]  head_dec;
    logic [FILL_W-1:0]  pos_plus;
    logic               sel_full;
    logic               lv_in_range;
    logic [FILL_W-1:0]  ins_pop;
    logic [FILL_W-1:0]  ins_fill;
    logic [FILL_W-1:0]  mv_fill;

    // ring position of list slot p in a level whose front sits at h
    function automatic logic [SLOT_W-1:0] phys(input logic [SLOT_W-1:0] h,
                                               input logic [FILL_W-1:0] p);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(h) + (FILL_W+1)'(p);
        if (s >= (FILL_W+1)'(MAX_PER_LEVEL))
        begin
            s = s - (FILL_W+1)'(MAX_PER_LEVEL);
        end
        return SLOT_W'(s);
    endfunction

    // clamped configuration
    always_comb
    begin
        if (levels_cfg_reg == '0)
            nl_eff = NLV_W'(1);
        else if (32'(levels_cfg_reg) > MAX_LEVELS)
            nl_eff = NLV_W'(MAX_LEVELS);
        else
            nl_eff = NLV_W'(levels_cfg_reg);

        if (cap_cfg_reg == '0)
            cap_eff = FILL_W'(1);
        else if (32'(cap_cfg_reg) > MAX_PER_LEVEL)
            cap_eff = FILL_W'(MAX_PER_LEVEL);
        else
            cap_eff = FILL_W'(cap_cfg_reg);
    end

    // one level table port per cycle
    always_comb
    begin
        unique case (state_reg)
            ST_POP, ST_MVW: sel = j_reg;
            ST_CHK:         sel = j_reg - 1'b1;
            ST_INS:         sel = '0;
            default:        sel = LVL_W'(lv_reg);
        endcase
    end

    assign fill_sel    = fill_reg[sel];
    assign head_sel    = head_reg[sel];
    assign head_dec    = (head_sel == '0) ? SLOT_W'(MAX_PER_LEVEL - 1) : head_sel - 1'b1;
    assign pos_plus    = pos_reg + 1'b1;
    assign sel_full    = fill_sel >= cap_eff;
    assign lv_in_range = lv_reg < nl_eff;

    // fill after push to front, with the hard ring limit
    assign ins_pop  = sel_full ? fill_sel - 1'b1 : fill_sel;
    assign ins_fill = ((32'(ins_pop) >= MAX_PER_LEVEL) ? ins_pop : ins_pop + 1'b1);
    assign mv_fill  = ((32'(fill_sel) >= MAX_PER_LEVEL) ? fill_sel : fill_sel + 1'b1);

    always_comb
    begin
        ram_req       = '0;
        ram_req.raddr = {sel, phys(head_sel, pos_reg)};
        ram_req.waddr = {sel, phys(head_sel, pos_reg)};
        ram_req.wdata = ram_rdata;
        unique case (state_reg)
            ST_RD:
            begin
                ram_req.re = lv_in_range && (pos_reg < fill_sel);
            end
            ST_SHR:
            begin
                ram_req.re    = pos_plus < fill_sel;
                ram_req.raddr = {sel, phys(head_sel, pos_plus)};
            end
            ST_SHW:
            begin
                ram_req.we = 1'b1;
            end
            ST_CHK:
            begin
                ram_req.re    = sel_full;
                ram_req.raddr = {sel, phys(head_sel, fill_sel - 1'b1)};
            end
            ST_MVW:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {sel, head_dec};
            end
            ST_INS:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {sel, head_dec};
                ram_req.wdata = blk_reg;
            end
            default:
            begin
                ram_req.re = 1'b0;
            end
        endcase
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign res_valid = state_reg == ST_RES;
    assign res.hit   = hit_reg;
    assign res.level = hit_reg ? HIT_LVL_W'(lv_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            act_reg        <= ACT_LOOKUP;
            blk_reg        <= '0;
            lv_reg         <= '0;
            pos_reg        <= '0;
            hit_reg        <= 1'b0;
            j_reg          <= '0;
            levels_cfg_reg <= CFG_LVL_W'(8);
            cap_cfg_reg    <= CFG_CAP_W'(64);
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEVELS)
                    levels_cfg_reg <= CFG_LVL_W'(cfg_data);
                else if (cfg_index == CFG_CAPACITY)
                    cap_cfg_reg <= CFG_CAP_W'(cfg_data);
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg   <= action;
                        blk_reg   <= block;
                        lv_reg    <= '0;
                        pos_reg   <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    if (!lv_in_range)
                        state_reg <= ST_RES;
                    else if (pos_reg >= fill_sel)
                    begin
                        lv_reg  <= lv_reg + 1'b1;
                        pos_reg <= '0;
                    end
                    else
                        state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (ram_rdata == blk_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        pos_reg   <= pos_plus;
                        state_reg <= ST_RD;
                    end
                end
                ST_RES:
                begin
                    if (res_ready)
                    begin
                        if (hit_reg && (act_reg == ACT_REMOVE || act_reg == ACT_PROMOTE))
                            state_reg <= ST_SHR;
                        else if (act_reg == ACT_PROMOTE)
                        begin
                            j_reg     <= LVL_W'(nl_eff - 1'b1);
                            state_reg <= ST_POP;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_SHR:
                begin
                    if (pos_plus < fill_sel)
                        state_reg <= ST_SHW;
                    else
                    begin
                        fill_reg[sel] <= fill_sel - 1'b1;
                        if (act_reg == ACT_PROMOTE)
                        begin
                            j_reg     <= LVL_W'(lv_reg);
                            state_reg <= ST_POP;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_SHW:
                begin
                    pos_reg   <= pos_plus;
                    state_reg <= ST_SHR;
                end
                ST_POP:
                begin
                    if (j_reg == '0)
                        state_reg <= ST_INS;
                    else
                    begin
                        if (sel_full)
                            fill_reg[sel] <= fill_sel - 1'b1;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (sel_full)
                    begin
                        fill_reg[sel] <= fill_sel - 1'b1;
                        state_reg     <= ST_MVW;
                    end
                    else
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= ST_POP;
                    end
                end
                ST_MVW:
                begin
                    fill_reg[sel] <= mv_fill;
                    head_reg[sel] <= head_dec;
                    j_reg         <= j_reg - 1'b1;
                    state_reg     <= ST_POP;
                end
                ST_INS:
                begin
                    fill_reg[sel] <= ins_fill;
                    head_reg[sel] <= head_dec;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MLLD_ASSERT(a_write_states, ram_req.we |-> (state_reg == ST_SHW || state_reg == ST_MVW || state_reg == ST_INS), "tag write outside a write state")
    `MLLD_ASSERT(a_cmp_after_read, (state_reg == ST_CMP) |-> $past(ram_req.re), "compare without a read issued")
    `MLLD_ASSERT_NEXT(a_ins_fills, state_reg == ST_INS, fill_reg[0] != '0, "level 0 empty after insert")
    `MLLD_ASSERT(a_search_in_range, (state_reg == ST_CMP) |-> lv_in_range, "search beyond active levels")

endmodule

@@ src/multi_level_lru_directory_top.sv @@
// top level of the multi-level lru directory: sequencer, tag memory, result register
// depends on mlld_pkg, mlld_tag_ram and mlld_ctrl
//
//   input channel (in_valid/in_ready, action, block): one beat per request;
//   action 0 looks up, 1 looks up and promotes or inserts, 2 removes
//   output channel (out_valid/out_ready, hit, hit_level): one beat per request,
//   in request order; hit_level is 0 on a miss
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
//   active levels, index 1 the entries per level; always ready; the user must
//   write it only idle, and the block itself does not enforce it
//   timing: one request at a time; the search compares the entries level by
//   level and leaves after the last level on a miss; the result waits in the
//   sequencer, then moves to the output register; a remove or promote hit then
//   shifts the entries behind the hit; a promote then steps from the hit level
//   (last level on a miss) down to 1, then inserts; in_ready rises right after
//   reset: all levels empty, 8 levels of 64 entries, no result pending; the
//   tag memory is not cleared since levels track their fill
//   stall: a beat waiting on out_ready holds in the output register; the
//   sequencer holds its next result, and in_ready stays low, until it frees up
module multi_level_lru_directory_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mlld_pkg::ACT_W-1:0]         action,
    input  logic [mlld_pkg::TAG_W-1:0]         block,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [mlld_pkg::HIT_LVL_W-1:0]     hit_level,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mlld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlld_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mlld_pkg::*;

    ram_req_t          ram_req;
    logic [TAG_W-1:0]  ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              out_valid_reg;
    result_t           out_res_reg;

    // tag storage, one ring of slots per level
    mlld_tag_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // search and reorder sequencer with the level fill and front pointers
    mlld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .block     (block),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register frees the sequencer from the receiver
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_res_reg.hit;
    assign hit_level = out_res_reg.level;

endmodule
